### rtl/bsei_pkg.sv
// Shared types for the Burning Ship escape-time iterator.
package bsei_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic finish;
    } t_stat;

    localparam int CFG_BITS   = 16;
    localparam int COORD_BITS = 32;
    localparam int PROD_BITS  = 2 * COORD_BITS;

endpackage

### rtl/bsei_ctrl.sv
// Controller state machine: load, multiply/update loop, result strobe.
module bsei_ctrl
    import bsei_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (i_stat.finish) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy   = 1'b0;
                o_cmd.load = i_start;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_UPD: begin
                o_cmd.upd = !i_stat.finish;
            end
            S_DONE: begin
                o_valid = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

### rtl/bsei_dpath.sv
// Datapath: iterate registers, squares/cross product, escape test, update.
module bsei_dpath
    import bsei_pkg::*;
#(
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  t_cmd                  i_cmd,
    input  logic signed [31:0]    i_c_real,
    input  logic signed [31:0]    i_c_imag,
    input  logic [CFG_BITS-1:0]   i_limit,
    output t_stat                 o_stat,
    output logic [CFG_BITS-1:0]   o_iter_count
);

    localparam int  SQ_SHIFT = 2 * FRAC_BITS + 2;
    localparam bit  CAN_ESC  = (SQ_SHIFT <= 63);
    localparam logic [PROD_BITS-1:0] THRESH =
        CAN_ESC ? (PROD_BITS'(1) << SQ_SHIFT) : '0;
    localparam int  LW = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
    localparam logic [LW-1:0] COUNT_MAX = LW'((65'd1 << COUNT_BITS) - 65'd1);
    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    logic signed [31:0]            r_zr, n_zr;
    logic signed [31:0]            r_zi, n_zi;
    logic signed [31:0]            r_cr, n_cr;
    logic signed [31:0]            r_ci, n_ci;
    logic [PROD_BITS-1:0]          r_sr, n_sr;
    logic [PROD_BITS-1:0]          r_si, n_si;
    logic [PROD_BITS-1:0]          r_pr, n_pr;
    logic [COUNT_BITS-1:0]         r_count, n_count;

    logic [31:0]                   mag_r, mag_i;
    logic [PROD_BITS-1:0]          esc_sum;
    logic [LW-1:0]                 lim_w, lim_c;
    logic                          lim_hit, escaped;
    logic signed [64:0]            diff;
    logic signed [64:0]            diff_sh;
    logic [64:0]                   cross_sh;
    logic signed [65:0]            sum_r, sum_i;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > SAT_HI) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Magnitudes; -2^31 maps to 2^31 in 32 unsigned bits
    assign mag_r = r_zr[31] ? 32'(-r_zr) : 32'(r_zr);
    assign mag_i = r_zi[31] ? 32'(-r_zi) : 32'(r_zi);

    assign esc_sum = r_sr + r_si;
    assign escaped = CAN_ESC && (esc_sum >= THRESH);

    assign lim_w   = LW'(i_limit);
    assign lim_c   = (lim_w > COUNT_MAX) ? COUNT_MAX : lim_w;
    assign lim_hit = (LW'(r_count) >= lim_c);

    assign o_stat.finish = lim_hit || escaped;
    assign o_iter_count  = CFG_BITS'(r_count);

    // Real: floor((sr - si) / 2^F) + cr
    assign diff    = $signed({1'b0, r_sr}) - $signed({1'b0, r_si});
    assign diff_sh = diff >>> FRAC_BITS;
    assign sum_r   = 66'(diff_sh) + 66'(r_cr);

    // Imag: trunc(2*|zr||zi| / 2^F) + ci, product is non-negative
    assign cross_sh = {r_pr, 1'b0} >> FRAC_BITS;
    assign sum_i    = $signed({1'b0, cross_sh}) + 66'(r_ci);

    always_comb begin
        n_zr    = r_zr;
        n_zi    = r_zi;
        n_cr    = r_cr;
        n_ci    = r_ci;
        n_sr    = r_sr;
        n_si    = r_si;
        n_pr    = r_pr;
        n_count = r_count;
        if (i_cmd.load) begin
            n_zr    = i_c_real;
            n_zi    = i_c_imag;
            n_cr    = i_c_real;
            n_ci    = i_c_imag;
            n_count = '0;
        end
        if (i_cmd.mul) begin
            n_sr = PROD_BITS'(mag_r) * PROD_BITS'(mag_r);
            n_si = PROD_BITS'(mag_i) * PROD_BITS'(mag_i);
            n_pr = PROD_BITS'(mag_r) * PROD_BITS'(mag_i);
        end
        if (i_cmd.upd) begin
            n_zr    = sat32(sum_r);
            n_zi    = sat32(sum_i);
            n_count = r_count + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_zr    <= n_zr;
        r_zi    <= n_zi;
        r_cr    <= n_cr;
        r_ci    <= n_ci;
        r_sr    <= n_sr;
        r_si    <= n_si;
        r_pr    <= n_pr;
        r_count <= n_count;
    end

endmodule

### rtl/burning_ship_escape_iter.sv
// Burning Ship escape-time iterator, top level.
//
// Usage: present a point on i_c_real / i_c_imag (signed Q4.28) and raise
// start; the item is taken at a clock edge where start is high and busy is
// low. The block then iterates z = (re^2 - im^2 + cr, |2*re*im| + ci) from
// z = c until |z|^2 >= 4 or the count reaches the iteration limit.
// The count appears on o_iter_count for exactly one cycle with o_valid high;
// the receiver must take it then, it cannot hold the result off.
// Sequence: each iteration has a multiply state (S_MUL), where the squares
// and cross product from the 32x32 multipliers are registered, then an
// update state (S_UPD) that runs the escape test and the update. A final
// S_DONE state gives the result strobe; a new item is taken only after it.
// One item is in flight at a time; busy stays high until the strobe is done.
// Configuration: i_cfg_we writes i_cfg_wdata into the iteration limit; write
// only while busy is low. Synchronous active-low reset returns to idle and
// sets the limit to 100.
module burning_ship_escape_iter
    import bsei_pkg::*;
#(
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [31:0]   i_c_real,
    input  logic signed [31:0]   i_c_imag,
    input  logic                 i_cfg_we,
    input  logic [CFG_BITS-1:0]  i_cfg_wdata,
    output logic                 o_valid,
    output logic [CFG_BITS-1:0]  o_iter_count
);

    localparam logic [CFG_BITS-1:0] LIMIT_RESET = CFG_BITS'(100);

    logic [CFG_BITS-1:0] r_iter_limit, n_iter_limit;
    t_cmd                cmd;
    t_stat               stat;

    assign n_iter_limit = i_cfg_we ? i_cfg_wdata : r_iter_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter_limit <= LIMIT_RESET;
        end else begin
            r_iter_limit <= n_iter_limit;
        end
    end

    bsei_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    bsei_dpath #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_c_real     (i_c_real),
        .i_c_imag     (i_c_imag),
        .i_limit      (r_iter_limit),
        .o_stat       (stat),
        .o_iter_count (o_iter_count)
    );

    // An accepted item keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after item accepted");

    // Result strobe comes only while busy, and the block is free right after
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    a_valid_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!busy && !o_valid))
        else $error("block not idle after result strobe");

endmodule
